// ===== hw/rtl/linear_probe_hash_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Shared property forms for the block checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht: same-cycle check failed");

// next-cycle implication
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht: next-cycle check failed");

`endif

// ===== hw/rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Command and status codes, field widths and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int HOME_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int HOME_N   = 2 ** HOME_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpht_req_if.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpht_req_if;
    logic                              valid;
    logic                              ready;
    logic [lpht_pkg::CMD_W-1:0]        command;
    logic [lpht_pkg::KEY_W-1:0]        key;
    logic [lpht_pkg::HOME_W-1:0]       home_slot;
    logic [lpht_pkg::VALUE_W-1:0]      value;

    modport source (output valid, command, key, home_slot, value, input ready);
    modport sink   (input valid, command, key, home_slot, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpht_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [lpht_pkg::STATUS_W-1:0]     status;
    logic [lpht_pkg::VALUE_W-1:0]      read_value;
    logic [lpht_pkg::COUNT_W-1:0]      entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing key/value table, one slot probed per cycle from one memory.
// ----------------------------------------------------------------------------
//  channel | role | beat
//  --------+------+----------------------------------------------
//  req     | sink | command, key, home_slot, value
//  rsp     | src  | status, read_value, entry_count
//
//  A command steps through accept, one memory read per probed slot and
//  result load; the table memory has one read port and one write port.
//  After reset a clearing pass writes all TABLE_DEPTH slots, one per cycle,
//  while req.ready stays low.
//  A new beat is taken while a result waits in the output register; a
//  finished command holds until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_PROBES  = 8,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int PCNT_W  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 1 + KEY_WIDTH + VALUE_WIDTH;

    typedef logic [IDX_W-1:0] home_lut_t [lpht_pkg::HOME_N];

    function automatic home_lut_t build_home_lut();
        home_lut_t lut;
        for (int i = 0; i < lpht_pkg::HOME_N; i++)
        begin
            lut[i] = IDX_W'(i % TABLE_DEPTH);
        end
        return lut;
    endfunction

    localparam home_lut_t HOME_LUT = build_home_lut();

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    lpht_pkg::state_t                state_reg, state_next;
    logic [IDX_W-1:0]                clr_addr_reg, clr_addr_next;
    logic [lpht_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0]            key_reg, key_next;
    logic [VALUE_WIDTH-1:0]          val_reg, val_next;
    logic [IDX_W-1:0]                slot_reg, slot_next;
    logic [PCNT_W-1:0]               pcnt_reg, pcnt_next;
    logic [CNT_W-1:0]                live_reg, live_next;
    logic [lpht_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [lpht_pkg::VALUE_W-1:0]    res_value_reg, res_value_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [lpht_pkg::STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [lpht_pkg::VALUE_W-1:0]    rsp_value_reg, rsp_value_next;
    logic [lpht_pkg::COUNT_W-1:0]    rsp_count_reg, rsp_count_next;
    logic [ENTRY_W-1:0]              rdata_reg;

    logic [IDX_W-1:0]                rd_addr;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [ENTRY_W-1:0]              wr_data;

    logic                            ent_valid;
    logic [KEY_WIDTH-1:0]            ent_key;
    logic [VALUE_WIDTH-1:0]          ent_value;
    logic                            key_eq;
    logic                            last_probe;
    logic [IDX_W-1:0]                slot_inc;
    logic [63:0]                     key_ext;
    logic [63:0]                     val_ext;
    logic [63:0]                     ent_value_ext;

    assign ent_valid     = rdata_reg[ENTRY_W-1];
    assign ent_key       = rdata_reg[KEY_WIDTH+VALUE_WIDTH-1 -: KEY_WIDTH];
    assign ent_value     = rdata_reg[VALUE_WIDTH-1:0];
    assign key_eq        = (ent_key == key_reg);
    assign last_probe    = (pcnt_reg == PCNT_W'(MAX_PROBES - 1));
    assign slot_inc      = (slot_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign key_ext       = 64'(req.key);
    assign val_ext       = 64'(req.value);
    assign ent_value_ext = 64'(ent_value);

    assign req.ready       = (state_reg == lpht_pkg::S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.read_value  = rsp_value_reg;
    assign rsp.entry_count = rsp_count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        slot_reg       <= slot_next;
        pcnt_reg       <= pcnt_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_count_reg  <= rsp_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        slot_next       = slot_reg;
        pcnt_next       = pcnt_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_count_next  = rsp_count_reg;
        rd_addr         = slot_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = '0;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            lpht_pkg::S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end

            lpht_pkg::S_IDLE:
            begin
                rd_addr = HOME_LUT[req.home_slot];
                if (req.valid)
                begin
                    cmd_next        = req.command;
                    key_next        = key_ext[KEY_WIDTH-1:0];
                    val_next        = val_ext[VALUE_WIDTH-1:0];
                    slot_next       = HOME_LUT[req.home_slot];
                    pcnt_next       = '0;
                    res_status_next = lpht_pkg::STAT_OK;
                    res_value_next  = '0;
                    state_next      = lpht_pkg::S_PROBE;
                end
            end

            lpht_pkg::S_PROBE:
            begin
                rd_addr   = slot_inc;
                slot_next = slot_inc;
                pcnt_next = pcnt_reg + 1'b1;
                case (cmd_reg)
                    lpht_pkg::CMD_INSERT:
                    begin
                        if (!ent_valid || key_eq)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = {1'b1, key_reg, val_reg};
                            slot_next  = slot_reg;
                            state_next = lpht_pkg::S_DONE;
                            if (!ent_valid)
                            begin
                                live_next = live_reg + 1'b1;
                            end
                        end
                        else if (last_probe)
                        begin
                            res_status_next = lpht_pkg::STAT_FULL;
                            state_next      = lpht_pkg::S_DONE;
                        end
                    end

                    lpht_pkg::CMD_REMOVE:
                    begin
                        if (ent_valid && key_eq)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = '0;
                            slot_next  = slot_reg;
                            live_next  = live_reg - 1'b1;
                            state_next = lpht_pkg::S_DONE;
                        end
                        else if (last_probe)
                        begin
                            res_status_next = lpht_pkg::STAT_MISSING;
                            state_next      = lpht_pkg::S_DONE;
                        end
                    end

                    default:
                    begin
                        if (ent_valid && key_eq)
                        begin
                            res_value_next = ent_value_ext[lpht_pkg::VALUE_W-1:0];
                            state_next     = lpht_pkg::S_DONE;
                        end
                        else if (last_probe)
                        begin
                            res_status_next = lpht_pkg::STAT_MISSING;
                            state_next      = lpht_pkg::S_DONE;
                        end
                    end
                endcase
            end

            lpht_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_value_next  = res_value_reg;
                    rsp_count_next  = lpht_pkg::COUNT_W'(live_reg);
                    state_next      = lpht_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_hash_table_unit_macros.svh"

module lpht_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                req_valid,
    input wire                                req_ready,
    input wire                                rsp_valid,
    input wire                                rsp_ready,
    input wire [lpht_pkg::STATUS_W-1:0]       status,
    input wire [lpht_pkg::VALUE_W-1:0]        read_value,
    input wire [lpht_pkg::COUNT_W-1:0]        entry_count
);

    `LPHT_ASSERT_IMP(a_status_code, clk, rst_n, rsp_valid, status == lpht_pkg::STAT_OK || status == lpht_pkg::STAT_MISSING || status == lpht_pkg::STAT_FULL)
    `LPHT_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp_valid && status != lpht_pkg::STAT_OK, read_value == '0)
    `LPHT_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)
    `LPHT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(read_value) && $stable(entry_count))

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count)
);

`default_nettype wire
